FILE: rtl/core/kest_pkg.sv
// ----------------------------------------------------------------------------
// kest_pkg
// Shared types and constants for the keyed event slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package kest_pkg;

  // Table geometry
  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_CNT_W  = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;

  // Low halves of the stored words for the speech and player action posts
  localparam logic [15:0] SPEECH_TAG = 16'd6;
  localparam logic [15:0] ACTION_TAG = 16'd2;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_POST_RAW    = 3'd0,
    KIND_POST_SPEECH = 3'd1,
    KIND_POST_PLAYER = 3'd2,
    KIND_CHECK       = 3'd3,
    KIND_TAKE        = 3'd4,
    KIND_CLEAR_FIRST = 3'd5,
    KIND_CLEAR_ALL   = 3'd6
  } kind_t;

  // Memory read request
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] addr;
  } rd_req_t;

  // Owner memory write
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] addr;
    logic [KEY_W-1:0]      data;
  } own_wr_t;

  // Payload memory write
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] addr;
    logic [VALUE_W-1:0]    data;
  } pay_wr_t;

  // Decoded request handed to the sequencer
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  // Result of one request
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] taken_value;
    logic               status;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/keyed_event_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_event_slot_table
// Table of owner-keyed pending event slots with post, check, take and clear.
//
// Input channel in_*: one request per transaction. in_tuser carries the
// request kind, in_tdata the key and value. Output channel out_*: one result
// per request, in request order: found, taken value and post status.
// cfg_wr_en/cfg_wr_data load the player key used by player action posts.
// A request's scan stops at the slot that settles it; a full scan (clear all,
// miss, full table) reads every slot, and an unused kind reads none.
// The sequencer takes one request at a time; the slot scan issues one owner
// read per cycle.
// A new request is accepted while the previous result still sits in the
// output register; if the receiver stalls, the next result waits inside the
// sequencer and no further request is taken until the output frees.
// Reset: the owner table reads as all free at once (per-slot valid bits), the
// player key returns to 1 and both channels come up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_event_slot_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] key, [47:16] value
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [0] found, [32:1] taken_value, [33] status
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic [kest_pkg::KEY_W-1:0]   player_key_r;
  logic                         out_valid_r;
  kest_pkg::res_t               out_res_r;

  kest_pkg::req_t               req;
  kest_pkg::req_t               req_eff;
  kest_pkg::res_t               res;
  logic                         res_valid;
  logic                         res_ready;
  kest_pkg::rd_req_t            rd;
  kest_pkg::own_wr_t            own_wr;
  kest_pkg::pay_wr_t            pay_wr;
  logic [kest_pkg::KEY_W-1:0]   rd_owner;
  logic [kest_pkg::VALUE_W-1:0] rd_value;

  // Unpack the request; player action posts get the player key in the top
  // half of value so the sequencer sees one request word
  assign req.kind  = in_tuser;
  assign req.key   = in_tdata[15:0];
  assign req.value = in_tdata[47:16];

  always_comb begin
    req_eff = req;
    if (req.kind == kest_pkg::KIND_POST_PLAYER) begin
      req_eff.value = {player_key_r, req.value[15:0]};
    end
  end

  // Player key register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_key_r <= 16'd1;
    end else if (cfg_wr_en) begin
      player_key_r <= cfg_wr_data;
    end
  end

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.taken_value, out_res_r.found};

  kest_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd        (rd),
    .own_wr    (own_wr),
    .pay_wr    (pay_wr),
    .rd_owner  (rd_owner),
    .rd_value  (rd_value)
  );

  kest_owner_store u_owner (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (rd),
    .wr       (own_wr),
    .rd_owner (rd_owner)
  );

  kest_payload_store u_payload (
    .clk      (clk),
    .rd       (rd),
    .wr       (pay_wr),
    .rd_value (rd_value)
  );

endmodule

`default_nettype wire

FILE: rtl/core/kest_owner_store.sv
// ----------------------------------------------------------------------------
// kest_owner_store
// Owner key memory, one read port and one write port, registered read data.
// Per-slot valid bits make the whole table read as free right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kest_owner_store (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kest_pkg::rd_req_t          rd,
  input  wire kest_pkg::own_wr_t          wr,
  output logic [kest_pkg::KEY_W-1:0]      rd_owner
);

  logic [kest_pkg::KEY_W-1:0]    mem [kest_pkg::SLOT_COUNT];
  logic [kest_pkg::SLOT_COUNT-1:0] valid_r;
  logic [kest_pkg::KEY_W-1:0]    rd_owner_r;

  // Valid bits: cleared at reset, set by the first write of a slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read; a slot never written reads as free
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_owner_r <= valid_r[rd.addr] ? mem[rd.addr] : '0;
    end
  end

  assign rd_owner = rd_owner_r;

endmodule

`default_nettype wire

FILE: rtl/core/kest_payload_store.sv
// ----------------------------------------------------------------------------
// kest_payload_store
// Pending value memory, one read port and one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kest_payload_store (
  input  wire logic                       clk,
  input  wire kest_pkg::rd_req_t          rd,
  input  wire kest_pkg::pay_wr_t          wr,
  output logic [kest_pkg::VALUE_W-1:0]    rd_value
);

  logic [kest_pkg::VALUE_W-1:0] mem [kest_pkg::SLOT_COUNT];
  logic [kest_pkg::VALUE_W-1:0] rd_value_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_value_r <= mem[rd.addr];
    end
  end

  assign rd_value = rd_value_r;

endmodule

`default_nettype wire

FILE: rtl/core/kest_seq.sv
// ----------------------------------------------------------------------------
// kest_seq
// Scan sequencer. Streams slot reads from slot 0 up, compares each owner in the
// cycle after its read was issued and writes back owner and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module kest_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request side
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire kest_pkg::req_t               req,
  // result side
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output kest_pkg::res_t                    res,
  // memory ports
  output kest_pkg::rd_req_t                 rd,
  output kest_pkg::own_wr_t                 own_wr,
  output kest_pkg::pay_wr_t                 pay_wr,
  input  wire logic [kest_pkg::KEY_W-1:0]   rd_owner,
  input  wire logic [kest_pkg::VALUE_W-1:0] rd_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [kest_pkg::SLOT_IDX_W-1:0] LAST_IDX =
    kest_pkg::SLOT_IDX_W'(kest_pkg::SLOT_COUNT - 1);
  localparam logic [kest_pkg::SLOT_CNT_W-1:0] SLOT_END =
    kest_pkg::SLOT_CNT_W'(kest_pkg::SLOT_COUNT);

  state_t                            state_r, state_nxt;
  kest_pkg::kind_t                   kind_r, kind_nxt;
  logic [kest_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic [kest_pkg::VALUE_W-1:0]      val_r, val_nxt;
  logic [kest_pkg::SLOT_IDX_W-1:0]   idx_r, idx_nxt;
  logic [kest_pkg::SLOT_CNT_W-1:0]   iss_r, iss_nxt;
  kest_pkg::res_t                    res_r, res_nxt;

  logic hit_post;
  logic hit_look;
  logic last_slot;
  logic stop;

  assign hit_post  = (rd_owner == key_r) || (rd_owner == '0);
  assign hit_look  = (key_r != '0) && (rd_owner == key_r);
  assign last_slot = (idx_r == LAST_IDX);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Next-state and memory access logic
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    iss_nxt   = iss_r;
    res_nxt   = res_r;
    stop      = 1'b0;
    rd        = '0;
    own_wr    = '0;
    pay_wr    = '0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt = kest_pkg::kind_t'(req.kind);
          res_nxt  = '0;
          // effective owner key and stored word per post kind
          case (kest_pkg::kind_t'(req.kind))
            kest_pkg::KIND_POST_SPEECH: begin
              key_nxt = req.key;
              val_nxt = {req.key, kest_pkg::SPEECH_TAG};
            end
            kest_pkg::KIND_POST_PLAYER: begin
              key_nxt = req.value[kest_pkg::VALUE_W-1:kest_pkg::VALUE_W-kest_pkg::KEY_W];
              val_nxt = {req.value[15:0], kest_pkg::ACTION_TAG};
            end
            default: begin
              key_nxt = req.key;
              val_nxt = req.value;
            end
          endcase
          if (req.kind > kest_pkg::KIND_CLEAR_ALL) begin
            // unused kind: empty result straight away
            state_nxt = S_DONE;
          end else begin
            rd.en     = 1'b1;
            rd.addr   = '0;
            idx_nxt   = '0;
            iss_nxt   = kest_pkg::SLOT_CNT_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        case (kind_r)
          kest_pkg::KIND_POST_RAW,
          kest_pkg::KIND_POST_SPEECH,
          kest_pkg::KIND_POST_PLAYER: begin
            if (hit_post) begin
              own_wr = '{en: 1'b1, addr: idx_r, data: key_r};
              pay_wr = '{en: 1'b1, addr: idx_r, data: val_r};
              stop   = 1'b1;
            end else if (last_slot) begin
              res_nxt.status = 1'b1;
              stop           = 1'b1;
            end
          end
          kest_pkg::KIND_CHECK: begin
            if (hit_look) begin
              res_nxt.found = 1'b1;
            end
            stop = hit_look || last_slot;
          end
          kest_pkg::KIND_TAKE: begin
            if (hit_look) begin
              own_wr              = '{en: 1'b1, addr: idx_r, data: '0};
              res_nxt.found       = 1'b1;
              res_nxt.taken_value = rd_value;
            end
            stop = hit_look || last_slot;
          end
          kest_pkg::KIND_CLEAR_FIRST: begin
            if (hit_look) begin
              own_wr        = '{en: 1'b1, addr: idx_r, data: '0};
              res_nxt.found = 1'b1;
            end
            stop = hit_look || last_slot;
          end
          kest_pkg::KIND_CLEAR_ALL: begin
            if (hit_look) begin
              own_wr        = '{en: 1'b1, addr: idx_r, data: '0};
              res_nxt.found = 1'b1;
            end
            stop = last_slot;
          end
          default: begin
            stop = 1'b1;
          end
        endcase

        if (stop) begin
          state_nxt = S_DONE;
        end else if (iss_r < SLOT_END) begin
          // keep the read stream one slot ahead of the compare
          rd.en   = 1'b1;
          rd.addr = iss_r[kest_pkg::SLOT_IDX_W-1:0];
          idx_nxt = iss_r[kest_pkg::SLOT_IDX_W-1:0];
          iss_nxt = iss_r + kest_pkg::SLOT_CNT_W'(1);
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    iss_r  <= iss_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire
